### hdl/lmss_pkg.sv
// Package for the scrolling LED matrix scanner: payload types, FSM states, constants.
package lmss_pkg;

	// Default number of glyphs the store can hold
	localparam int GLYPHS_DEF = 16;
	// Columns shown per frame, and widths of the window and column counters
	localparam int WINDOW     = 16;
	localparam int WIN_W      = 4;
	localparam int COL_W      = 4;
	// Glyph count register width
	localparam int CNT_W      = 5;

	// Request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SHOW  = 1'b1;

	// Input beat
	typedef struct packed {
		logic       req_type;
		logic [8:0] byte_addr;
		logic [7:0] byte_value;
		logic [7:0] offset;
	} in_beat_t;

	// Output beat
	typedef struct packed {
		logic [31:0] shift_word;
		logic [3:0]  column;
		logic        last;
	} out_beat_t;

	// Frame sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_RUN
	} seq_state_t;

endpackage

### hdl/led_matrix_scroll_scanner.sv
// Top level of the scrolling LED matrix scanner: store, frame sequencer, output buffer.
//
// A write beat stores one glyph byte. A show beat first reduces the glyph part of its offset
// modulo the glyph count by repeated subtraction, one step a cycle until the remainder is in
// range (floor(offset/16)/glyph_count steps), then, while the output has room, reads one column
// a cycle from the two half memories (upper and lower bytes) for 16 columns; the next beat is
// taken after the last read is issued. Results leave through an output register with a skid
// stage, so a stall on the output holds the column reads back but words already built drain on
// their own. The glyph store has no reset; a frame must only cover columns that have been
// written.
module led_matrix_scroll_scanner #(
	parameter int GLYPHS = lmss_pkg::GLYPHS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  lmss_pkg::in_beat_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output lmss_pkg::out_beat_t            out_data,
	input  logic                           cfg_we,
	input  logic [lmss_pkg::CNT_W-1:0]     cfg_data
);

	localparam int GW    = (GLYPHS > 1) ? $clog2(GLYPHS) : 1;
	localparam int GCW   = $clog2(GLYPHS + 1);
	localparam int DEPTH = GLYPHS * lmss_pkg::WINDOW;
	localparam int RAW   = $clog2(DEPTH);
	localparam int STORE_BYTES = GLYPHS * 32;

	// Configuration register
	logic [lmss_pkg::CNT_W-1:0] glyph_count_q;
	logic [GCW-1:0]             g_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= lmss_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			glyph_count_q <= cfg_data;
		end
	end

	// Glyphs in use, saturated to 1..GLYPHS
	always_comb begin
		priority if (glyph_count_q == '0) begin
			g_lim = GCW'(1);
		end else if (32'(glyph_count_q) > 32'(GLYPHS)) begin
			g_lim = GCW'(GLYPHS);
		end else begin
			g_lim = GCW'(glyph_count_q);
		end
	end

	// Sequencer state
	lmss_pkg::seq_state_t       state_q, state_nxt;
	logic [3:0]                 red_q;
	logic [GW-1:0]              glyph_q;
	logic [lmss_pkg::COL_W-1:0] col_q;
	logic [lmss_pkg::WIN_W-1:0] win_q;

	logic in_acc;
	logic issue;
	logic red_done;
	logic win_end;

	// Output buffer state
	logic                       inflight_s1;
	logic [lmss_pkg::WIN_W-1:0] win_s1;
	logic                       last_s1;
	logic                       out_valid_q;
	lmss_pkg::out_beat_t        out_q;
	logic                       skid_valid_q;
	lmss_pkg::out_beat_t        skid_q;
	logic                       pop;
	logic [1:0]                 occ;
	logic                       room;

	assign in_acc   = in_valid && !in_stall;
	assign red_done = 32'(red_q) < 32'(g_lim);
	assign win_end  = win_q == lmss_pkg::WIN_W'(lmss_pkg::WINDOW - 1);

	// Credit check: words in flight plus buffered must fit the two output registers
	assign pop  = out_valid_q && !out_stall;
	assign occ  = 2'(inflight_s1) + 2'(out_valid_q) + 2'(skid_valid_q) - 2'(pop);
	assign room = occ <= 2'd1;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lmss_pkg::ST_IDLE: begin
				if (in_acc && in_data.req_type == lmss_pkg::REQ_SHOW) begin
					state_nxt = lmss_pkg::ST_REDUCE;
				end
			end
			lmss_pkg::ST_REDUCE: begin
				if (red_done) begin
					state_nxt = lmss_pkg::ST_RUN;
				end
			end
			lmss_pkg::ST_RUN: begin
				if (room && win_end) begin
					state_nxt = lmss_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lmss_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		unique case (state_q)
			lmss_pkg::ST_IDLE:   in_stall = 1'b0;
			lmss_pkg::ST_REDUCE: in_stall = 1'b1;
			lmss_pkg::ST_RUN:    issue    = room;
			default:             in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmss_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Offset reduction and column stepping
	always_ff @(posedge clk) begin
		if (state_q == lmss_pkg::ST_IDLE && in_acc) begin
			red_q <= in_data.offset[7:4];
			col_q <= in_data.offset[3:0];
			win_q <= '0;
		end else if (state_q == lmss_pkg::ST_REDUCE) begin
			if (red_done) begin
				glyph_q <= GW'(red_q);
			end else begin
				red_q <= red_q - 4'(g_lim);
			end
		end else if (issue) begin
			win_q <= win_q + lmss_pkg::WIN_W'(1);
			col_q <= col_q + lmss_pkg::COL_W'(1);
			if (col_q == '1) begin
				if (GCW'(glyph_q) + GCW'(1) == g_lim) begin
					glyph_q <= '0;
				end else begin
					glyph_q <= glyph_q + GW'(1);
				end
			end
		end
	end

	// Glyph store: upper and lower half columns in separate memories
	logic [GW-1:0]  wr_glyph;
	logic [RAW-1:0] waddr;
	logic [RAW-1:0] raddr;
	logic           wr_ok;
	logic           we_up;
	logic           we_lo;
	logic [7:0]     upper_rd;
	logic [7:0]     lower_rd;

	assign wr_glyph = GW'(in_data.byte_addr[8:5]);
	assign waddr    = RAW'({wr_glyph, in_data.byte_addr[3:0]});
	assign raddr    = RAW'({glyph_q, col_q});
	assign wr_ok    = in_acc && in_data.req_type == lmss_pkg::REQ_WRITE
		&& 32'(in_data.byte_addr) < 32'(STORE_BYTES);
	assign we_up    = wr_ok && !in_data.byte_addr[4];
	assign we_lo    = wr_ok && in_data.byte_addr[4];

	lmss_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_upper (
		.clk   (clk),
		.we    (we_up),
		.waddr (waddr),
		.wdata (in_data.byte_value),
		.re    (issue),
		.raddr (raddr),
		.rdata (upper_rd)
	);

	lmss_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_lower (
		.clk   (clk),
		.we    (we_lo),
		.waddr (waddr),
		.wdata (in_data.byte_value),
		.re    (issue),
		.raddr (raddr),
		.rdata (lower_rd)
	);

	// Read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_s1 <= 1'b0;
		end else begin
			inflight_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			win_s1  <= win_q;
			last_s1 <= win_end;
		end
	end

	// Word assembled from the read data
	lmss_pkg::out_beat_t arrive;

	always_comb begin
		arrive.shift_word = {~(16'd1 << win_s1), lower_rd, upper_rd};
		arrive.column     = win_s1;
		arrive.last       = last_s1;
	end

	// Output register and skid stage, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || inflight_s1;
			skid_valid_q <= skid_valid_q && inflight_s1;
		end else if (inflight_s1) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register and skid stage, payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (inflight_s1) begin
					skid_q <= arrive;
				end
			end else if (inflight_s1) begin
				out_q <= arrive;
			end
		end else if (inflight_s1) begin
			skid_q <= arrive;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hdl/lmss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
